// File: rtl/av_sync_frame_scheduler_macros.svh
// assertion helpers shared by the rtl
`ifndef AV_SYNC_FRAME_SCHEDULER_MACROS_SVH
`define AV_SYNC_FRAME_SCHEDULER_MACROS_SVH

// same-cycle implication, checked out of reset
`define AVSFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("avsfs same-cycle check failed");

// next-cycle implication, checked out of reset
`define AVSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("avsfs next-cycle check failed");

`endif

// File: rtl/avsfs_pkg.sv
package avsfs_pkg;

    // field widths
    localparam int W_US    = 48;
    localparam int W_DELAY = 21;
    localparam int W_CALC  = 50;

    // timing constants in microseconds
    localparam logic [W_DELAY-1:0]       DEFAULT_DELAY = 21'd40000;
    localparam logic signed [W_CALC-1:0] MAX_STEP      = 50'sd1000000;
    localparam logic signed [W_CALC-1:0] DROP_LATE     = -50'sd100000;
    localparam logic [W_DELAY-1:0]       THR_MIN       = 21'd10000;
    localparam logic [W_DELAY-1:0]       THR_MAX       = 21'd100000;
    localparam logic [W_DELAY-1:0]       DELAY_CAP     = 21'd500000;
    localparam logic [W_US:0]            PRESENT_SLACK = 49'd1000;

    typedef enum logic [1:0] {
        ACT_WAIT       = 2'd0,
        ACT_PRESENT    = 2'd1,
        ACT_DROP       = 2'd2,
        ACT_RESET_DONE = 2'd3
    } action_t;

    typedef enum logic {
        MODE_OFFER = 1'b0,
        MODE_RESET = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                  mode;
        logic signed [W_US-1:0] frame_pts_us;
        logic signed [W_US-1:0] audio_clock_us;
        logic [W_US-1:0]        now_us;
        logic                   more_frames_waiting;
    } offer_t;

    typedef struct packed {
        logic signed [W_US-1:0] last_pts;
        logic [W_DELAY-1:0]     last_delay;
        logic [W_US-1:0]        timer_base;
    } sync_state_t;

    typedef struct packed {
        action_t     action;
        sync_state_t next_state;
    } decision_t;

endpackage

// File: rtl/avsfs_if.sv
// offer channel: one frame offer or timing reset per word
interface avsfs_offer_if;
    logic                              valid;
    logic                              ready;
    avsfs_pkg::mode_t                  mode;
    logic signed [avsfs_pkg::W_US-1:0] frame_pts_us;
    logic signed [avsfs_pkg::W_US-1:0] audio_clock_us;
    logic [avsfs_pkg::W_US-1:0]        now_us;
    logic                              more_frames_waiting;

    modport source (output valid, mode, frame_pts_us, audio_clock_us, now_us,
                    more_frames_waiting, input ready);
    modport sink (input valid, mode, frame_pts_us, audio_clock_us, now_us,
                  more_frames_waiting, output ready);
endinterface

// result channel: one action per word
interface avsfs_result_if;
    logic               valid;
    logic               ready;
    avsfs_pkg::action_t action;

    modport source (output valid, action, input ready);
    modport sink (input valid, action, output ready);
endinterface

// configuration write channel
interface avsfs_cfg_if;
    logic valid;
    logic ready;
    logic audio_master;

    modport source (output valid, audio_master, input ready);
    modport sink (input valid, audio_master, output ready);
endinterface

// File: rtl/avsfs_decide.sv
module avsfs_decide
(
    input  logic                   audio_master,
    input  avsfs_pkg::offer_t      item,
    input  avsfs_pkg::sync_state_t state,
    output avsfs_pkg::decision_t   decision
);

    logic signed [avsfs_pkg::W_CALC-1:0]  pts_w;
    logic signed [avsfs_pkg::W_CALC-1:0]  last_w;
    logic signed [avsfs_pkg::W_CALC-1:0]  aclk_w;
    logic signed [avsfs_pkg::W_CALC-1:0]  step;
    logic signed [avsfs_pkg::W_CALC-1:0]  diff;
    logic signed [avsfs_pkg::W_CALC-1:0]  d_w;
    logic signed [avsfs_pkg::W_CALC-1:0]  thr_w;
    logic signed [avsfs_pkg::W_CALC-1:0]  sum;
    logic                                 step_ok;
    logic                                 late;
    logic                                 due;
    logic [avsfs_pkg::W_DELAY-1:0]        d;
    logic [avsfs_pkg::W_DELAY-1:0]        thr;
    logic [avsfs_pkg::W_DELAY-1:0]        actual;
    logic [avsfs_pkg::W_US:0]             target;
    logic [avsfs_pkg::W_US:0]             now_slack;
    logic [avsfs_pkg::W_US-1:0]           timer_new;

    // sign-extend timestamps to the working width
    assign pts_w  = {{2{item.frame_pts_us[47]}}, item.frame_pts_us};
    assign last_w = {{2{state.last_pts[47]}}, state.last_pts};
    assign aclk_w = {{2{item.audio_clock_us[47]}}, item.audio_clock_us};

    // nominal delay from the timestamp step, falling back to the last delay or the default delay
    assign step    = pts_w - last_w;
    assign step_ok = (step > 50'sd0) && (step < avsfs_pkg::MAX_STEP);
    assign d = step_ok ? step[avsfs_pkg::W_DELAY-1:0]
             : ((state.last_delay != '0) ? state.last_delay : avsfs_pkg::DEFAULT_DELAY);
    assign d_w = $signed({29'b0, d});

    // a/v difference and late drop test
    assign diff = pts_w - aclk_w;
    assign late = audio_master && item.more_frames_waiting && (diff < avsfs_pkg::DROP_LATE);

    // sync threshold clamped to its window
    assign thr = (d < avsfs_pkg::THR_MIN) ? avsfs_pkg::THR_MIN
               : ((d > avsfs_pkg::THR_MAX) ? avsfs_pkg::THR_MAX : d);
    assign thr_w = $signed({29'b0, thr});
    assign sum   = d_w + diff;

    // corrected delay
    always_comb
    begin
        actual = d;
        if (audio_master)
        begin
            if (diff <= -thr_w)
            begin
                actual = '0;
            end
            else if (diff >= thr_w)
            begin
                if (sum > $signed({29'b0, avsfs_pkg::DELAY_CAP}))
                begin
                    actual = avsfs_pkg::DELAY_CAP;
                end
                else
                begin
                    actual = sum[avsfs_pkg::W_DELAY-1:0];
                end
            end
        end
    end

    // presentation target and saturated timer update
    assign target    = {1'b0, state.timer_base} + {28'b0, actual};
    assign now_slack = {1'b0, item.now_us} + avsfs_pkg::PRESENT_SLACK;
    assign due       = (now_slack >= target);
    assign timer_new = (actual == '0) ? item.now_us
                     : (target[avsfs_pkg::W_US] ? '1 : target[avsfs_pkg::W_US-1:0]);

    // action and next state
    always_comb
    begin
        decision.action     = avsfs_pkg::ACT_WAIT;
        decision.next_state = state;
        if (item.mode == avsfs_pkg::MODE_RESET)
        begin
            decision.action                = avsfs_pkg::ACT_RESET_DONE;
            decision.next_state.last_pts    = item.frame_pts_us;
            decision.next_state.last_delay  = avsfs_pkg::DEFAULT_DELAY;
            decision.next_state.timer_base  = item.now_us;
        end
        else if (late)
        begin
            decision.action                = avsfs_pkg::ACT_DROP;
            decision.next_state.last_pts    = item.frame_pts_us;
            decision.next_state.last_delay  = d;
            decision.next_state.timer_base  = item.now_us;
        end
        else if (due)
        begin
            decision.action                = avsfs_pkg::ACT_PRESENT;
            decision.next_state.last_pts    = item.frame_pts_us;
            decision.next_state.last_delay  = d;
            decision.next_state.timer_base  = timer_new;
        end
    end

endmodule

// File: rtl/av_sync_frame_scheduler.sv
// Audio-master video frame pacer. Each offer word carries a frame timestamp,
// the audio clock, the current time and a queue hint, and yields one action
// word: wait, present, drop, or timing reset done. Offers are taken one per
// cycle while the result is not stalled. An accepted offer is held in the
// input register, decided there combinationally, and its action word and
// the timing state update are registered together when it moves on (input
// register, then result register). A stalled result blocks only when both
// registers are full. audio_master is written through the config channel,
// which is always ready, and should be changed only while no offer is
// pending.
`include "av_sync_frame_scheduler_macros.svh"

module av_sync_frame_scheduler
(
    input  logic                  clk,
    input  logic                  rst_n,
    avsfs_cfg_if.sink             cfg,
    avsfs_offer_if.sink           offer,
    avsfs_result_if.source        result
);

    logic                   audio_master_reg;
    logic                   audio_master_next;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    avsfs_pkg::offer_t      s1_item_reg;
    avsfs_pkg::offer_t      s1_item_next;
    avsfs_pkg::sync_state_t state_reg;
    avsfs_pkg::sync_state_t state_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    avsfs_pkg::action_t     res_action_reg;
    avsfs_pkg::action_t     res_action_next;
    avsfs_pkg::decision_t   decision;
    logic                   s1_fire;
    logic                   in_take;

    // handshakes
    assign cfg.ready     = 1'b1;
    assign s1_fire       = s1_valid_reg && (!res_valid_reg || result.ready);
    assign offer.ready   = !s1_valid_reg || s1_fire;
    assign in_take       = offer.valid && offer.ready;
    assign result.valid  = res_valid_reg;
    assign result.action = res_action_reg;

    // decision logic
    avsfs_decide u_decide
    (
        .audio_master (audio_master_reg),
        .item         (s1_item_reg),
        .state        (state_reg),
        .decision     (decision)
    );

    // next values
    always_comb
    begin
        audio_master_next = audio_master_reg;
        if (cfg.valid)
        begin
            audio_master_next = cfg.audio_master;
        end

        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        if (in_take)
        begin
            s1_valid_next                    = 1'b1;
            s1_item_next.mode                = offer.mode;
            s1_item_next.frame_pts_us        = offer.frame_pts_us;
            s1_item_next.audio_clock_us      = offer.audio_clock_us;
            s1_item_next.now_us              = offer.now_us;
            s1_item_next.more_frames_waiting = offer.more_frames_waiting;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        state_next      = state_reg;
        res_valid_next  = res_valid_reg;
        res_action_next = res_action_reg;
        if (s1_fire)
        begin
            state_next      = decision.next_state;
            res_valid_next  = 1'b1;
            res_action_next = decision.action;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // control and timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio_master_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            audio_master_reg <= audio_master_next;
            s1_valid_reg     <= s1_valid_next;
            res_valid_reg    <= res_valid_next;
            state_reg        <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_item_reg    <= s1_item_next;
        res_action_reg <= res_action_next;
    end

    // timing state moves only when a word is decided
    `AVSFS_ASSERT_NEXT(a_state_hold, clk, rst_n, !s1_fire, $stable(state_reg))

    // a decided word always lands in the result register
    `AVSFS_ASSERT_NEXT(a_fire_result, clk, rst_n, s1_fire, res_valid_reg)

    // a timing reset word re-bases the timer on its own time
    `AVSFS_ASSERT_NEXT(a_reset_rebase, clk, rst_n,
        s1_fire && (s1_item_reg.mode == avsfs_pkg::MODE_RESET),
        (res_action_reg == avsfs_pkg::ACT_RESET_DONE) &&
        (state_reg.timer_base == $past(s1_item_reg.now_us)))

    // drops happen only with audio as master clock
    `AVSFS_ASSERT_NOW(a_drop_master, clk, rst_n,
        s1_fire && (decision.action == avsfs_pkg::ACT_DROP), audio_master_reg)

    // a full, stalled pipe takes no new word
    `AVSFS_ASSERT_NOW(a_stall_block, clk, rst_n, s1_valid_reg && !s1_fire, !offer.ready)

endmodule

// File: tb/tb_av_sync_frame_scheduler.sv
`timescale 1ns / 100ps

module tb_av_sync_frame_scheduler;

    localparam int      RESET_CYCLES  = 7;
    localparam int      SETTLE_CYCLES = 6;
    localparam int      TAIL_CYCLES   = 12;
    localparam int      STALL_LIMIT   = 2000;
    localparam int      PHASE_COUNT   = 7;
    localparam int      PHASE_ITEMS   = 250;

    // pacing constants in microseconds
    localparam longint  FALLBACK_US   = 40000;
    localparam longint  STEP_CEIL_US  = 1000000;
    localparam longint  LATE_DROP_US  = -100000;
    localparam longint  THR_LO_US     = 10000;
    localparam longint  THR_HI_US     = 100000;
    localparam longint  CORR_CAP_US   = 500000;
    localparam longint  SLACK_US      = 1000;

    localparam longint  PTS_HI        = 64'sd140737488355327;
    localparam longint  PTS_LO        = -64'sd140737488355328;
    localparam logic [47:0] NOW_HI    = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] NOW_MASK  = 64'h0000_FFFF_FFFF_FFFF;

    typedef enum logic {
        REQ_OFFER,
        REQ_CFG
    } req_kind_t;

    typedef struct {
        req_kind_t         kind;
        logic              am;
        avsfs_pkg::offer_t word;
    } sched_req_t;

    logic clk = 1'b0;
    logic rst_n;

    avsfs_cfg_if    cfg_bus();
    avsfs_offer_if  offer_bus();
    avsfs_result_if result_bus();

    av_sync_frame_scheduler u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .offer  (offer_bus),
        .result (result_bus)
    );

    always #2 clk = ~clk;

    // pacing state mirrored by the predictor
    logic signed [47:0] pace_last_pts     = '0;
    logic [20:0]        pace_last_delay   = '0;
    logic [47:0]        pace_timer        = '0;
    logic               pace_audio_master = 1'b0;

    sched_req_t         frame_backlog[$];
    avsfs_pkg::action_t pace_actions[$];
    avsfs_pkg::offer_t  in_flight_word;

    int fault_count  = 0;
    int idle_cycles  = 0;
    int quiet_cycles = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int source_calm  = 0;
    int sink_calm    = 0;

    // store the timing state after a present, drop or re-base
    function automatic void pace_commit(input longint pts, input longint step,
                                        input logic [63:0] stamp);
        pace_last_delay = step[20:0];
        pace_last_pts   = pts[47:0];
        pace_timer      = (stamp > NOW_MASK) ? NOW_HI : stamp[47:0];
    endfunction

    // decide the action for one offer word and advance the pacing state
    function automatic avsfs_pkg::action_t pace_frame(input avsfs_pkg::offer_t w);
        longint      pts;
        longint      aclk;
        longint      step;
        longint      skew;
        longint      thr;
        longint      corr;
        logic [63:0] now64;
        logic [63:0] target;
        pts   = longint'($signed(w.frame_pts_us));
        aclk  = longint'($signed(w.audio_clock_us));
        now64 = {16'b0, w.now_us};
        if (w.mode == avsfs_pkg::MODE_RESET)
        begin
            pace_commit(pts, FALLBACK_US, now64);
            return avsfs_pkg::ACT_RESET_DONE;
        end
        // nominal delay from the timestamp step
        step = pts - longint'(pace_last_pts);
        if (step <= 0 || step >= STEP_CEIL_US)
            step = longint'(pace_last_delay);
        if (step <= 0)
            step = FALLBACK_US;
        skew = pts - aclk;
        // late frame with a successor queued
        if (pace_audio_master && w.more_frames_waiting && skew < LATE_DROP_US)
        begin
            pace_commit(pts, step, now64);
            return avsfs_pkg::ACT_DROP;
        end
        // correct toward the audio clock
        corr = step;
        if (pace_audio_master)
        begin
            thr = (step < THR_LO_US) ? THR_LO_US : ((step > THR_HI_US) ? THR_HI_US : step);
            if (skew <= -thr)
                corr = 0;
            else if (skew >= thr)
            begin
                corr = step + skew;
                if (corr > CORR_CAP_US)
                    corr = CORR_CAP_US;
            end
        end
        target = {16'b0, pace_timer} + 64'(corr);
        if (now64 + 64'(SLACK_US) >= target)
        begin
            pace_commit(pts, step, (corr <= 0) ? now64 : target);
            return avsfs_pkg::ACT_PRESENT;
        end
        return avsfs_pkg::ACT_WAIT;
    endfunction

    // idle length: mostly none, some short, a few long, with calm stretches
    function automatic int random_pause(ref int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 3)
        begin
            calm_left = int'($urandom_range(20, 60));
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(5, 40));
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[47:0];
    endfunction

    function automatic void queue_offer(input avsfs_pkg::mode_t m, input longint pts,
                                        input longint aclk, input logic [47:0] now,
                                        input logic more);
        sched_req_t req;
        req.kind                     = REQ_OFFER;
        req.am                       = 1'b0;
        req.word.mode                = m;
        req.word.frame_pts_us        = pts[47:0];
        req.word.audio_clock_us      = aclk[47:0];
        req.word.now_us              = now;
        req.word.more_frames_waiting = more;
        frame_backlog.push_back(req);
    endfunction

    function automatic void queue_config(input logic am);
        sched_req_t req;
        req.kind = REQ_CFG;
        req.am   = am;
        req.word = '0;
        frame_backlog.push_back(req);
    endfunction

    // timestamp step between frames, with odd steps now and then
    function automatic longint pick_step();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return longint'($urandom_range(20000, 50000));
        if (r < 80)
            return longint'($urandom_range(1, 9999));
        if (r < 88)
            return longint'($urandom_range(100001, 999999));
        if (r < 93)
            return -longint'($urandom_range(0, 50000));
        return longint'($urandom_range(1000000, 1500000));
    endfunction

    // audio clock offset from the frame timestamp
    function automatic longint pick_skew();
        int     r;
        longint mag;
        r = int'($urandom_range(0, 99));
        if (r < 75)
            mag = longint'($urandom_range(0, 30000));
        else if (r < 93)
            mag = longint'($urandom_range(50000, 200000));
        else
            mag = longint'($urandom_range(200000, 900000));
        return ($urandom_range(0, 1) != 0) ? mag : -mag;
    endfunction

    // offer and config driver
    always @(posedge clk)
    begin
        sched_req_t req;
        logic       offer_on;
        logic       cfg_on;
        if (!rst_n)
        begin
            offer_bus.valid <= 1'b0;
            cfg_bus.valid   <= 1'b0;
        end
        else
        begin
            offer_on = offer_bus.valid;
            cfg_on   = cfg_bus.valid;
            // retire accepted words
            if (offer_bus.valid && offer_bus.ready)
            begin
                pace_actions.push_back(pace_frame(in_flight_word));
                offer_on = 1'b0;
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                pace_audio_master = cfg_bus.audio_master;
                cfg_on = 1'b0;
            end
            quiet_cycles = (offer_on || pace_actions.size() != 0) ? 0 : quiet_cycles + 1;
            // launch the next word
            if (!offer_on && !cfg_on && frame_backlog.size() != 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (frame_backlog[0].kind == REQ_CFG)
                begin
                    if (quiet_cycles >= SETTLE_CYCLES)
                    begin
                        req = frame_backlog.pop_front();
                        cfg_bus.audio_master <= req.am;
                        cfg_on = 1'b1;
                    end
                end
                else
                begin
                    req = frame_backlog.pop_front();
                    in_flight_word = req.word;
                    offer_bus.mode                <= req.word.mode;
                    offer_bus.frame_pts_us        <= req.word.frame_pts_us;
                    offer_bus.audio_clock_us      <= req.word.audio_clock_us;
                    offer_bus.now_us              <= req.word.now_us;
                    offer_bus.more_frames_waiting <= req.word.more_frames_waiting;
                    offer_on = 1'b1;
                    gap_left = random_pause(source_calm);
                end
            end
            offer_bus.valid <= offer_on;
            cfg_bus.valid   <= cfg_on;
        end
    end

    // action monitor with random backpressure
    always @(posedge clk)
    begin
        avsfs_pkg::action_t want;
        logic               take;
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (pace_actions.size() == 0)
                begin
                    $error("action word with no pending expectation: got %0d",
                           result_bus.action);
                    fault_count++;
                end
                else
                begin
                    want = pace_actions.pop_front();
                    if (result_bus.action !== want)
                    begin
                        $error("action mismatch: expected %0d, got %0d", want,
                               result_bus.action);
                        fault_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                take = 1'b0;
            end
            else
            begin
                take = 1'b1;
                stall_left = random_pause(sink_calm);
            end
            result_bus.ready <= take;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (offer_bus.valid && offer_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
            || (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        longint      walk_pts;
        logic [47:0] walk_now;
        int          r;
        rst_n                         = 1'b0;
        offer_bus.valid               = 1'b0;
        offer_bus.mode                = avsfs_pkg::MODE_OFFER;
        offer_bus.frame_pts_us        = '0;
        offer_bus.audio_clock_us      = '0;
        offer_bus.now_us              = '0;
        offer_bus.more_frames_waiting = 1'b0;
        cfg_bus.valid                 = 1'b0;
        cfg_bus.audio_master          = 1'b0;
        result_bus.ready              = 1'b0;

        // directed: default delay, extremes and saturation with audio ignored
        queue_config(1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 0, 0, 48'd0, 1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 0, 0, 48'd39000, 1'b0);
        queue_offer(avsfs_pkg::MODE_RESET, PTS_HI, PTS_LO, NOW_HI, 1'b1);
        queue_offer(avsfs_pkg::MODE_OFFER, PTS_LO, PTS_HI, NOW_HI, 1'b1);
        queue_offer(avsfs_pkg::MODE_RESET, 1000, 0, NOW_HI, 1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 1500, PTS_LO, NOW_HI, 1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 2000, PTS_HI, NOW_HI, 1'b1);
        // directed: audio master drop, snap, cap, threshold clamps and bounds
        queue_config(1'b1);
        queue_offer(avsfs_pkg::MODE_RESET, 0, 0, 48'd1000000, 1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 40000, 200000, 48'd1000000, 1'b1);
        queue_offer(avsfs_pkg::MODE_OFFER, 80000, 300000, 48'd1000000, 1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 120000, -1000000, 48'd1000100, 1'b1);
        queue_offer(avsfs_pkg::MODE_OFFER, 120000, -1000000, 48'd1499000, 1'b1);
        queue_offer(avsfs_pkg::MODE_OFFER, 125000, 113000, 48'd1516000, 1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 325000, 175000, 48'd1865999, 1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 325000, 175000, 48'd1866000, 1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 365000, 405000, 48'd1866000, 1'b1);
        queue_offer(avsfs_pkg::MODE_OFFER, 405000, 505000, 48'd1866000, 1'b1);
        queue_offer(avsfs_pkg::MODE_OFFER, 445000, 545001, 48'd1866000, 1'b1);
        queue_offer(avsfs_pkg::MODE_OFFER, 1445000, 1445000, 48'd1900000, 1'b0);
        queue_config(1'b0);
        queue_offer(avsfs_pkg::MODE_OFFER, 1485000, PTS_LO, 48'd1950000, 1'b1);

        // random phases: playback walks with seeks and some noise
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            queue_config((ph % 3) != 1);
            walk_pts = longint'($urandom_range(0, 1000000000));
            if (ph == 2)
                walk_now = NOW_HI - 48'($urandom_range(0, 2000000));
            else
                walk_now = 48'($urandom_range(0, 1000000000));
            queue_offer(avsfs_pkg::MODE_RESET, walk_pts, pick_skew(), walk_now,
                        1'($urandom_range(0, 1)));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = int'($urandom_range(0, 99));
                if (r < 7)
                    queue_offer(avsfs_pkg::mode_t'($urandom_range(0, 1)),
                                longint'($signed(rand48())), longint'($signed(rand48())),
                                rand48(), 1'($urandom_range(0, 1)));
                else if (r < 10)
                begin
                    walk_pts += longint'($urandom_range(0, 4000000)) - 2000000;
                    walk_now += 48'($urandom_range(0, 100000));
                    queue_offer(avsfs_pkg::MODE_RESET, walk_pts, pick_skew(), walk_now,
                                1'($urandom_range(0, 1)));
                end
                else
                begin
                    if ($urandom_range(0, 1) != 0)
                        walk_pts += pick_step();
                    walk_now += 48'($urandom_range(0, 50000));
                    queue_offer(avsfs_pkg::MODE_OFFER, walk_pts, walk_pts + pick_skew(),
                                walk_now, $urandom_range(0, 9) < 7);
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // drain
        while (frame_backlog.size() != 0 || offer_bus.valid || cfg_bus.valid
               || pace_actions.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
